>>> src/tcppm_pkg.sv
// ----------------------------------------------------------------------------
// tcppm_pkg: shared types and constants for the period and phase meter
// Field widths, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
package tcppm_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned SilWidth  = 16;
  localparam int unsigned PhWidth   = 10;
  localparam int unsigned QDepth    = 2;

  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegFscale  = 2'd1;
  localparam logic [1:0] RegMinPer  = 2'd2;
  localparam logic [1:0] RegMaxPer  = 2'd3;

  localparam logic [SilWidth-1:0]  TimeoutRst = 16'd100;
  localparam logic [TimeWidth-1:0] FscaleRst  = 32'd1000000000;
  localparam logic [TimeWidth-1:0] MinPerRst  = 32'd0;
  localparam logic [TimeWidth-1:0] MaxPerRst  = 32'hFFFF_FFFF;

  // job handed from the channel tracker to the divider side
  typedef struct packed {
    logic [TimeWidth-1:0] period_a;
    logic [TimeWidth-1:0] period_b;
    logic [TimeWidth-1:0] lag;
    logic                 missed;
    logic                 a_in_range;
    logic                 b_in_range;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_PH,
    ST_DIV_FR,
    ST_DONE
  } back_state_e;

endpackage

>>> src/two_channel_period_phase_meter_unit.sv
// ----------------------------------------------------------------------------
// two_channel_period_phase_meter_unit: two-channel period and phase meter
// Input-capture period, phase lag, frequency and range checks per poll tick.
// ----------------------------------------------------------------------------
// One tick item enters on s_axis; one result leaves on m_axis per tick.
// The channel tracker updates both channels in the transfer cycle and pushes
// a job into a two-entry queue, so it keeps taking ticks while results wait.
// A shared one-bit-per-cycle divider forms 1000*lag / period_a (42 steps)
// then frequency_scale / period_a (32 steps); a job with period_a zero skips
// both divisions. The divider takes a new job only once the last result has
// been taken, so the sustained rate is set by that single divider.
// Registers are written on cfg_* with cfg_valid_i/cfg_ready_o; cfg_ready_o
// is always high. Reset sets registers to their defaults and clears all
// channel state, the queue and the divider. When m_axis_tready is low the
// result holds, the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module two_channel_period_phase_meter_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // edge_a, capture_a, edge_b, capture_b, now_time, then unused bits
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // period_a_out, period_b_out, phase_permille, frequency_a, a_missed_pulse,
  // a_in_range, b_in_range, then zero fill
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [tcppm_pkg::SilWidth-1:0]  tlim_q;
  logic [tcppm_pkg::TimeWidth-1:0] fsc_q, minp_q, maxp_q;
  logic            fj_valid, fj_ready, bj_valid, bj_ready;
  tcppm_pkg::job_t fj, bj;
  logic            unused;

  assign cfg_ready_o = 1'b1;
  assign unused = ^s_axis_tdata[103:98];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlim_q <= tcppm_pkg::TimeoutRst;
      fsc_q  <= tcppm_pkg::FscaleRst;
      minp_q <= tcppm_pkg::MinPerRst;
      maxp_q <= tcppm_pkg::MaxPerRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tcppm_pkg::RegTimeout: tlim_q <= cfg_data_i[15:0];
        tcppm_pkg::RegFscale:  fsc_q  <= cfg_data_i;
        tcppm_pkg::RegMinPer:  minp_q <= cfg_data_i;
        tcppm_pkg::RegMaxPer:  maxp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcppm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .edge_a_i(s_axis_tdata[0]), .capture_a_i(s_axis_tdata[32:1]),
    .edge_b_i(s_axis_tdata[33]), .capture_b_i(s_axis_tdata[65:34]),
    .now_time_i(s_axis_tdata[97:66]),
    .timeout_limit_i(tlim_q), .min_period_i(minp_q), .max_period_i(maxp_q),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  tcppm_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  tcppm_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .frequency_scale_i(fsc_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

>>> src/tcppm_front.sv
// ----------------------------------------------------------------------------
// tcppm_front: channel tracker
// Updates periods and silence counters per tick and builds a divider job.
// ----------------------------------------------------------------------------
module tcppm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                edge_a_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]     capture_a_i,
  input  logic                                edge_b_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]     capture_b_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]     now_time_i,
  input  logic [tcppm_pkg::SilWidth-1:0]      timeout_limit_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]     min_period_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]     max_period_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output tcppm_pkg::job_t                     job_o
);

  logic [tcppm_pkg::TimeWidth-1:0] last_a_q, last_a_d, per_a_q, per_a_d;
  logic [tcppm_pkg::TimeWidth-1:0] last_b_q, last_b_d, per_b_q, per_b_d;
  logic [tcppm_pkg::SilWidth-1:0]  sil_a_q, sil_a_d, sil_b_q, sil_b_d;
  logic [tcppm_pkg::SilWidth:0]    inc_a, inc_b;
  logic                            acc;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign acc         = in_valid_i & job_ready_i;

  assign inc_a = {1'b0, sil_a_q} + 1'b1;
  assign inc_b = {1'b0, sil_b_q} + 1'b1;

  always_comb begin
    last_a_d = last_a_q;
    per_a_d  = per_a_q;
    sil_a_d  = sil_a_q;
    if (edge_a_i) begin
      per_a_d  = (sil_a_q < timeout_limit_i) ? capture_a_i - last_a_q : '0;
      last_a_d = capture_a_i;
      sil_a_d  = '0;
    end else if (inc_a >= {1'b0, timeout_limit_i}) begin
      sil_a_d = timeout_limit_i;
      per_a_d = '0;
    end else begin
      sil_a_d = inc_a[tcppm_pkg::SilWidth-1:0];
    end
    last_b_d = last_b_q;
    per_b_d  = per_b_q;
    sil_b_d  = sil_b_q;
    if (edge_b_i) begin
      per_b_d  = (sil_b_q < timeout_limit_i) ? capture_b_i - last_b_q : '0;
      last_b_d = capture_b_i;
      sil_b_d  = '0;
    end else if (inc_b >= {1'b0, timeout_limit_i}) begin
      sil_b_d = timeout_limit_i;
      per_b_d = '0;
    end else begin
      sil_b_d = inc_b[tcppm_pkg::SilWidth-1:0];
    end
  end

  always_comb begin
    job_o.period_a   = per_a_d;
    job_o.period_b   = per_b_d;
    job_o.lag        = last_b_d - (last_a_d - per_a_d);
    job_o.missed     = (now_time_i - (last_b_d - per_b_d)) < (now_time_i - last_a_d);
    job_o.a_in_range = (min_period_i < per_a_d) && (per_a_d < max_period_i);
    job_o.b_in_range = (min_period_i < per_b_d) && (per_b_d < max_period_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= '0;
      per_a_q  <= '0;
      sil_a_q  <= '0;
      last_b_q <= '0;
      per_b_q  <= '0;
      sil_b_q  <= '0;
    end else if (acc) begin
      last_a_q <= last_a_d;
      per_a_q  <= per_a_d;
      sil_a_q  <= sil_a_d;
      last_b_q <= last_b_d;
      per_b_q  <= per_b_d;
      sil_b_q  <= sil_b_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sil_a_q <= $past(timeout_limit_i) || $stable(sil_a_q) || sil_a_q == '0 ||
    $past(sil_a_q) > $past(timeout_limit_i))
    else $error("silence a above limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(per_a_q) && $stable(per_b_q))
    else $error("state moved without transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && edge_a_i |=> sil_a_q == '0)
    else $error("edge did not clear silence");

endmodule

>>> src/tcppm_queue.sv
// ----------------------------------------------------------------------------
// tcppm_queue: job fifo
// Short queue between the channel tracker and the divider side.
// ----------------------------------------------------------------------------
module tcppm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  tcppm_pkg::job_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output tcppm_pkg::job_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(tcppm_pkg::QDepth);

  tcppm_pkg::job_t     mem_q [tcppm_pkg::QDepth];
  logic [PtrW-1:0]     wp_q, rp_q;
  logic [PtrW:0]       cnt_q;
  logic                wr, rd;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(tcppm_pkg::QDepth));
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(tcppm_pkg::QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count not tracking");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wp_q == rp_q)
    else $error("pointers differ when empty");

endmodule

>>> src/tcppm_back.sv
// ----------------------------------------------------------------------------
// tcppm_back: divider side
// Radix-2 restoring divider shared by the phase and frequency quotients.
// ----------------------------------------------------------------------------
module tcppm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  tcppm_pkg::job_t                   job_i,
  input  logic [tcppm_pkg::TimeWidth-1:0]   frequency_scale_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [111:0]                      m_axis_tdata
);

  localparam int unsigned W  = tcppm_pkg::TimeWidth;
  localparam int unsigned DW = W + 10;           // 1000*lag fits in W+10 bits
  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [tcppm_pkg::PhWidth:0] PhMod = 1000;

  tcppm_pkg::back_state_e st_q, st_d;
  tcppm_pkg::job_t        job_q;
  logic [DW-1:0]          num_q, num_d;     // dividend shifting out, quotient in
  logic [W:0]             rem_q, rem_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [tcppm_pkg::PhWidth-1:0] ph_q, ph_d;
  logic [W-1:0]           fr_q, fr_d;
  logic [W+1:0]           trial;
  logic [W:0]             rsh;
  logic [tcppm_pkg::PhWidth:0] ph2, ph_sub;
  logic [DW-1:0]          prod;
  logic                   ld;

  assign rsh   = {rem_q[W-1:0], num_q[DW-1]};
  assign trial = {1'b0, rsh} - {2'b0, job_q.period_a};
  // phase quotient kept mod 1000 as its bits come out, msb first
  assign ph2    = {ph_q, ~trial[W+1]};
  assign ph_sub = ph2 - PhMod;
  assign prod  = (DW)'(job_i.lag) * (DW)'(10'd1000);

  assign job_ready_o = (st_q == tcppm_pkg::ST_IDLE);
  assign ld = job_valid_i & job_ready_o;

  always_comb begin
    st_d  = st_q;
    num_d = num_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    ph_d  = ph_q;
    fr_d  = fr_q;
    case (st_q)
      tcppm_pkg::ST_IDLE: begin
        if (ld) begin
          num_d = prod;
          rem_d = '0;
          cnt_d = CW'(DW);
          ph_d  = '0;
          fr_d  = '0;
          st_d  = (job_i.period_a == '0) ? tcppm_pkg::ST_DONE : tcppm_pkg::ST_DIV_PH;
        end
      end
      tcppm_pkg::ST_DIV_PH, tcppm_pkg::ST_DIV_FR: begin
        if (trial[W+1]) begin
          rem_d = rsh;
          num_d = {num_q[DW-2:0], 1'b0};
        end else begin
          rem_d = trial[W:0];
          num_d = {num_q[DW-2:0], 1'b1};
        end
        if (st_q == tcppm_pkg::ST_DIV_PH) begin
          ph_d = (ph2 >= PhMod) ? ph_sub[tcppm_pkg::PhWidth-1:0]
                                : ph2[tcppm_pkg::PhWidth-1:0];
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          if (st_q == tcppm_pkg::ST_DIV_PH) begin
            st_d  = tcppm_pkg::ST_DIV_FR;
            num_d = {frequency_scale_i, 10'd0};
            rem_d = '0;
            cnt_d = CW'(W);
          end else begin
            st_d = tcppm_pkg::ST_DONE;
          end
        end
      end
      tcppm_pkg::ST_DONE: begin
        if (m_axis_tready) st_d = tcppm_pkg::ST_IDLE;
      end
      default: st_d = tcppm_pkg::ST_IDLE;
    endcase
    if (st_q == tcppm_pkg::ST_DIV_FR && cnt_q == CW'(1))
      fr_d = num_d[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= tcppm_pkg::ST_IDLE;
      num_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      ph_q  <= '0;
      fr_q  <= '0;
    end else begin
      st_q  <= st_d;
      num_q <= num_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      ph_q  <= ph_d;
      fr_q  <= fr_d;
    end
  end

  assign m_axis_tvalid = (st_q == tcppm_pkg::ST_DONE);
  // period_a_out, period_b_out, phase_permille, frequency_a, a_missed_pulse,
  // a_in_range, b_in_range, then zero fill
  assign m_axis_tdata = {3'b0, job_q.b_in_range, job_q.a_in_range, job_q.missed,
                         fr_q, ph_q, job_q.period_b, job_q.period_a};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ph_q < 10'd1000)
    else $error("phase out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && job_q.period_a == '0 |-> ph_q == '0 && fr_q == '0)
    else $error("zero period gave nonzero quotient");

endmodule
